// ===== hdl/tsc_pkg.sv =====
// Shared types, constants and the quarter-wave sine generator of the
// three-phase sine commutator. No dependencies.
package tsc_pkg;

  localparam int SINE_BITS    = 10;
  localparam int QUARTER_BITS = SINE_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;
  localparam int SENSOR_BITS  = 12;

  localparam int ANGLE_W = 16;
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int AMP_W   = 32;
  localparam int DUTY_W  = 47;
  localparam int CNT_W   = 17;
  localparam int HALF_W  = 24;
  localparam int SUM_W   = 64;

  localparam logic [SENSOR_BITS-1:0] RAW_MIN = SENSOR_BITS'(20);
  localparam logic [SENSOR_BITS-1:0] RAW_MAX = SENSOR_BITS'((1 << SENSOR_BITS) - 1 - 20);

  localparam logic [ANGLE_W-1:0] QUARTER_TURN   = 16'd16384;
  localparam logic [ANGLE_W-1:0] THIRD_TURN     = 16'd21845;
  localparam logic [ANGLE_W-1:0] TWO_THIRD_TURN = 16'd43691;
  localparam logic signed [15:0] DEAD_BAND      = 16'sd32;

  localparam logic signed [PROD_W-1:0] AMP_POS   = 51'sd1073741824;
  localparam logic signed [PROD_W-1:0] AMP_NEG   = -51'sd1073741824;
  localparam logic signed [PROD_W-1:0] DUTY_HALF = 51'sd35184372088832;
  localparam logic signed [PROD_W-1:0] DUTY_FULL = 51'sd70368744177664;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    CFG_ENABLED     = 3'd0,
    CFG_MODE        = 3'd1,
    CFG_POLE_PAIRS  = 3'd2,
    CFG_ELEC_OFFSET = 3'd3,
    CFG_ANGLE_STEP  = 3'd4,
    CFG_AMP_CAP     = 3'd5,
    CFG_PWM_TOP     = 3'd6
  } cfg_idx_t;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_ANG  = 10'b0000000010,
    S_AMP  = 10'b0000000100,
    S_SAT  = 10'b0000001000,
    S_MSIN = 10'b0000010000,
    S_DUTY = 10'b0000100000,
    S_MLO  = 10'b0001000000,
    S_MHI  = 10'b0010000000,
    S_SUM  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  // Sine of j/(4*QUARTER) turn by a Q30 Taylor series, rounded to Q15.
  function automatic logic [14:0] quarter_sine(input int unsigned j);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint sum;
    longint q15;
    r    = 64'(j) << (30 - QUARTER_BITS);
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    q15 = (sum + 16384) >>> 15;
    if (q15 > 32767) begin
      q15 = 32767;
    end
    return q15[14:0];
  endfunction

  function automatic logic [ANGLE_W-1:0] phase_offset(input logic [1:0] p);
    logic [ANGLE_W-1:0] off;
    unique case (p)
      2'd1:    off = THIRD_TURN;
      2'd2:    off = TWO_THIRD_TURN;
      default: off = '0;
    endcase
    return off;
  endfunction

endpackage

// ===== hdl/tsc_mul.sv =====
// Shared signed multiplier of the commutator with a registered product.
// Depends on tsc_pkg.
module tsc_mul
  import tsc_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = PROD_W'(a) * PROD_W'(b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== hdl/tsc_sine_rom.sv =====
// Full-wave sine lookup built from a quarter-wave constant table.
// Depends on tsc_pkg.
module tsc_sine_rom
  import tsc_pkg::*;
(
  input  logic [SINE_BITS-1:0] idx,
  output logic signed [15:0]   sine
);

  localparam logic [14:0] Q_TOP = quarter_sine(QUARTER);

  logic [14:0]             qtab [QUARTER];
  logic [1:0]              quad;
  logic [QUARTER_BITS-1:0] low;
  logic [QUARTER_BITS-1:0] mirror;
  logic [14:0]             mag;

  for (genvar g = 0; g < QUARTER; g++) begin : g_qtab
    localparam logic [14:0] VAL = quarter_sine(g);
    assign qtab[g] = VAL;
  end

  assign quad   = idx[SINE_BITS-1:SINE_BITS-2];
  assign low    = idx[QUARTER_BITS-1:0];
  assign mirror = QUARTER_BITS'(~low + 1'b1);

  always_comb begin
    if (!quad[0]) begin
      mag = qtab[low];
    end else if (low == '0) begin
      mag = Q_TOP;
    end else begin
      mag = qtab[mirror];
    end
  end

  assign sine = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// ===== hdl/three_phase_sine_commutator.sv =====
// Top level of the three-phase sine commutator: sequencer, registers, outputs.
// Depends on tsc_pkg, tsc_mul and tsc_sine_rom.
//
//   channel | direction | handshake         | payload
//   cfg     | in        | cfg_valid/ready   | cfg_index, cfg_data
//   in      | in        | in_valid/in_stall | effort, mech_angle, sensor_ready/raw
//   out     | out       | out_valid/stall   | duty_u, duty_v, duty_w, stage_on
//
// A normal transaction runs S_ANG, S_AMP and S_SAT, then five steps per phase
// for three phases (S_MSIN, S_DUTY, S_MLO, S_MHI, S_SUM) and then S_DONE.
// A sensor fault one goes straight to S_DONE; a disabled one stays in S_IDLE.
// Reset is synchronous and loads the state and configuration defaults.
// A stalled result holds the sequencer in its final step, so no input is taken.
module three_phase_sine_commutator
  import tsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_effort,
  input  logic [15:0]        in_mech_angle,
  input  logic               in_sensor_ready,
  input  logic [11:0]        in_sensor_raw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        out_duty_u,
  output logic [16:0]        out_duty_v,
  output logic [16:0]        out_duty_w,
  output logic               out_stage_on
);

  state_t state_r, state_nxt;

  logic              enabled_r;
  logic              mode_r;
  logic [6:0]        pole_pairs_r;
  logic [15:0]       elec_offset_r;
  logic [15:0]       angle_step_r;
  logic [15:0]       amp_cap_r;
  logic [15:0]       pwm_top_r;

  logic [ANGLE_W-1:0]       angle_r;
  logic signed [15:0]       effort_r;
  logic [15:0]              mech_r;
  logic signed [AMP_W-1:0]  amp_r;
  logic signed [15:0]       sine_r;
  logic [DUTY_W-1:0]        duty_r;
  logic [40:0]              acc_r;
  logic [1:0]               phase_r;
  logic [CNT_W-1:0]         cnt_r [3];
  logic                     stage_r;
  logic                     out_valid_r;
  logic [CNT_W-1:0]         out_u_r, out_v_r, out_w_r;
  logic                     out_stage_r;

  logic                      in_fire;
  logic                      sensor_bad;
  logic                      out_load;
  logic [CNT_W-1:0]          scale;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic [1:0]                look_phase;
  logic [ANGLE_W-1:0]        look_angle;
  logic signed [15:0]        rom_sine;
  logic signed [PROD_W-1:0]  duty_sum;
  logic [SUM_W-1:0]          cnt_sum;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign scale     = {1'b0, pwm_top_r} + CNT_W'(1);
  assign sensor_bad = !in_sensor_ready || (in_sensor_raw < RAW_MIN) ||
                      (in_sensor_raw > RAW_MAX);

  assign look_phase = (state_r == S_SUM) ? 2'(phase_r + 2'd1) : 2'd0;
  assign look_angle = angle_r + phase_offset(look_phase);
  assign duty_sum   = prod_r + DUTY_HALF;
  assign cnt_sum    = (SUM_W'(prod_r[39:0]) << HALF_W) + SUM_W'(acc_r);

  tsc_sine_rom u_rom (
    .idx  (look_angle[ANGLE_W-1:ANGLE_W-SINE_BITS]),
    .sine (rom_sine)
  );

  tsc_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_ANG: begin
        mul_a = $signed({17'b0, mech_r});
        mul_b = $signed({11'b0, pole_pairs_r});
      end
      S_AMP: begin
        mul_a = MUL_A_W'(effort_r);
        mul_b = $signed({2'b0, amp_cap_r});
      end
      S_MSIN: begin
        mul_a = MUL_A_W'(amp_r);
        mul_b = MUL_B_W'(sine_r);
      end
      S_MLO: begin
        mul_a = $signed({9'b0, duty_r[HALF_W-1:0]});
        mul_b = $signed({1'b0, scale});
      end
      S_MHI: begin
        mul_a = $signed({10'b0, duty_r[DUTY_W-1:HALF_W]});
        mul_b = $signed({1'b0, scale});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && enabled_r) begin
          state_nxt = (mode_r && sensor_bad) ? S_DONE : S_ANG;
        end
      end
      S_ANG:  state_nxt = S_AMP;
      S_AMP:  state_nxt = S_SAT;
      S_SAT:  state_nxt = S_MSIN;
      S_MSIN: state_nxt = S_DUTY;
      S_DUTY: state_nxt = S_MLO;
      S_MLO:  state_nxt = S_MHI;
      S_MHI:  state_nxt = S_SUM;
      S_SUM:  state_nxt = (phase_r == 2'd2) ? S_DONE : S_MSIN;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      enabled_r     <= 1'b0;
      mode_r        <= 1'b1;
      pole_pairs_r  <= 7'd7;
      elec_offset_r <= 16'd0;
      angle_step_r  <= 16'd52;
      amp_cap_r     <= 16'd9830;
      pwm_top_r     <= 16'd4095;
      angle_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ENABLED:     enabled_r     <= cfg_data[0];
          CFG_MODE:        mode_r        <= cfg_data[0];
          CFG_POLE_PAIRS:  pole_pairs_r  <= cfg_data[6:0];
          CFG_ELEC_OFFSET: elec_offset_r <= cfg_data;
          CFG_ANGLE_STEP:  angle_step_r  <= cfg_data;
          CFG_AMP_CAP:     amp_cap_r     <= cfg_data;
          CFG_PWM_TOP:     pwm_top_r     <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire && enabled_r && !mode_r) begin
        if (in_effort > DEAD_BAND) begin
          angle_r <= angle_r + angle_step_r;
        end else if (in_effort < -DEAD_BAND) begin
          angle_r <= angle_r - angle_step_r;
        end
      end
      if ((state_r == S_AMP) && mode_r) begin
        angle_r <= prod_r[ANGLE_W-1:0] + elec_offset_r + QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      effort_r <= in_effort;
      mech_r   <= in_mech_angle;
      stage_r  <= !(mode_r && sensor_bad);
      if (mode_r && sensor_bad) begin
        cnt_r[0] <= '0;
        cnt_r[1] <= '0;
        cnt_r[2] <= '0;
      end
    end
    if (state_r == S_SAT) begin
      priority if (prod_r > AMP_POS) begin
        amp_r <= AMP_POS[AMP_W-1:0];
      end else if (prod_r < AMP_NEG) begin
        amp_r <= AMP_NEG[AMP_W-1:0];
      end else begin
        amp_r <= prod_r[AMP_W-1:0];
      end
      sine_r  <= rom_sine;
      phase_r <= 2'd0;
    end
    if (state_r == S_DUTY) begin
      priority if (duty_sum < 0) begin
        duty_r <= '0;
      end else if (duty_sum > DUTY_FULL) begin
        duty_r <= DUTY_FULL[DUTY_W-1:0];
      end else begin
        duty_r <= duty_sum[DUTY_W-1:0];
      end
    end
    if (state_r == S_MHI) begin
      acc_r <= prod_r[40:0];
    end
    if (state_r == S_SUM) begin
      cnt_r[phase_r] <= cnt_sum[62:46];
      phase_r        <= 2'(phase_r + 2'd1);
      sine_r         <= rom_sine;
    end
    if (out_load) begin
      out_u_r     <= cnt_r[0];
      out_v_r     <= cnt_r[1];
      out_w_r     <= cnt_r[2];
      out_stage_r <= stage_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_duty_u   = out_u_r;
  assign out_duty_v   = out_v_r;
  assign out_duty_w   = out_w_r;
  assign out_stage_on = out_stage_r;

endmodule

// ===== hdl/tsc_checker.sv =====
// Port-level checker of the three-phase sine commutator and its bind.
// Depends on three_phase_sine_commutator.
module tsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [16:0]        out_duty_u,
  input logic [16:0]        out_duty_v,
  input logic [16:0]        out_duty_w,
  input logic               out_stage_on
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_duty_u) && $stable(out_duty_v) &&
                               $stable(out_duty_w) && $stable(out_stage_on))
    else $error("stalled result changed");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stage_on |-> out_duty_u == 17'd0 && out_duty_v == 17'd0 &&
                                   out_duty_w == 17'd0)
    else $error("nonzero duty with the stage off");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in progress");

endmodule

bind three_phase_sine_commutator tsc_checker u_tsc_checker (.*);
